### rtl/vts_pkg.sv
// Shared types, widths and codes of the volume trilinear sampler.
// Used by vts_front, vts_blend and the top level; depends on nothing.
package vts_pkg;

    // Volume and number formats.
    localparam int MAX_EXTENT = 32;
    localparam int EXT_W      = $clog2(MAX_EXTENT) + 1;
    localparam int IDX_W      = $clog2(MAX_EXTENT);
    localparam int FRAC_BITS  = 8;
    localparam int COORD_W    = 15;
    localparam int VOX_W      = 16;
    localparam int OUT_W      = 16;
    localparam int ADDR_W     = 15;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int CORNERS    = 8;

    // Datapath widths: fractions, weights, products and the sum.
    localparam int FR_W   = COORD_W + 2;
    localparam int PQ_W   = 2 * FR_W;
    localparam int WT_W   = 3 * FR_W;
    localparam int PROD_W = WT_W + VOX_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int XY_W   = 2 * IDX_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_INTERP_MODE  = 3'd0,
        REG_CHECK_BOUNDS = 3'd1,
        REG_FILL_VALUE   = 3'd2,
        REG_EXTENT_X     = 3'd3,
        REG_EXTENT_Y     = 3'd4,
        REG_EXTENT_Z     = 3'd5
    } cfg_reg_t;

    // Configuration as seen by the datapath.
    typedef struct packed
    {
        logic                    interp_mode;
        logic                    check_bounds;
        logic signed [OUT_W-1:0] fill_value;
        logic [EXT_W-1:0]        extent_x;
        logic [EXT_W-1:0]        extent_y;
        logic [EXT_W-1:0]        extent_z;
    } cfg_t;

    // An extent of zero counts as one, any value above the maximum as the maximum.
    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        begin
            if (e == '0)
                r = EXT_W'(1);
            else if (e > EXT_W'(MAX_EXTENT))
                r = EXT_W'(MAX_EXTENT);
            else
                r = e;
            return r;
        end
    endfunction

endpackage

### rtl/vts_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Stand-alone; holds one copy of the voxel store in the sampler.
module vts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; holds its data while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/vts_front.sv
// Front end of the sampler: clamps the point, forms corner indices, fractions,
// corner weights and the eight voxel addresses. Depends on vts_pkg.
module vts_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  vts_pkg::cfg_t                          cfg,
    input  logic                                   in_valid,
    input  logic                                   cmd,
    input  logic [vts_pkg::ADDR_W-1:0]             voxel_addr,
    input  logic signed [vts_pkg::VOX_W-1:0]       voxel_data,
    input  logic signed [vts_pkg::COORD_W-1:0]     coord_x,
    input  logic signed [vts_pkg::COORD_W-1:0]     coord_y,
    input  logic signed [vts_pkg::COORD_W-1:0]     coord_z,
    output logic                                   ram_we,
    output logic [vts_pkg::ADDR_W-1:0]             ram_waddr,
    output logic [vts_pkg::VOX_W-1:0]              ram_wdata,
    output logic [vts_pkg::ADDR_W-1:0]             ram_raddr [vts_pkg::CORNERS],
    output logic                                   s3_valid,
    output logic                                   s3_outside,
    output logic signed [vts_pkg::WT_W-1:0]        s3_weight [vts_pkg::CORNERS]
);

    localparam int FRAC   = vts_pkg::FRAC_BITS;
    localparam int IDX_W  = vts_pkg::IDX_W;
    localparam int FR_W   = vts_pkg::FR_W;
    localparam int CW     = vts_pkg::COORD_W;
    localparam int CC_W   = IDX_W + FRAC;
    localparam int EXT_W  = vts_pkg::EXT_W;
    localparam int XY_W   = vts_pkg::XY_W;
    localparam logic signed [FR_W-1:0] ONE = FR_W'(1 << FRAC);

    logic signed [CW-1:0] coord [3];
    logic [EXT_W-1:0]     ext_in [3];

    // Stage 1 combinational values, one set per axis.
    logic [EXT_W-1:0]       ext_c [3];
    logic [IDX_W-1:0]       last_c [3];
    logic [CC_W-1:0]        maxc [3];
    logic signed [FR_W-1:0] c_w [3];
    logic [2:0]             below;
    logic [2:0]             above;
    logic [CC_W-1:0]        cc [3];
    logic [IDX_W-1:0]       lo_c [3];
    logic [IDX_W-1:0]       hi_c [3];
    logic signed [FR_W-1:0] p_c [3];
    logic signed [FR_W-1:0] n_c [3];

    // Stage 1 registers.
    logic                    s1_valid_reg;
    logic                    s1_cmd_reg;
    logic [vts_pkg::ADDR_W-1:0] s1_addr_reg;
    logic [vts_pkg::VOX_W-1:0]  s1_data_reg;
    logic                    s1_inside_reg;
    logic [IDX_W-1:0]        s1_lo_reg [3];
    logic [IDX_W-1:0]        s1_hi_reg [3];
    logic signed [FR_W-1:0]  s1_p_reg [3];
    logic signed [FR_W-1:0]  s1_n_reg [3];

    // Stage 2 values and registers.
    logic [XY_W-1:0]              xy_next [4];
    logic signed [vts_pkg::PQ_W-1:0] pq_next [4];
    logic                         s2_valid_reg;
    logic                         s2_cmd_reg;
    logic [vts_pkg::ADDR_W-1:0]   s2_addr_reg;
    logic [vts_pkg::VOX_W-1:0]    s2_data_reg;
    logic                         s2_inside_reg;
    logic [XY_W-1:0]              s2_xy_reg [4];
    logic signed [vts_pkg::PQ_W-1:0] s2_pq_reg [4];
    logic [IDX_W-1:0]             s2_zlo_reg;
    logic [IDX_W-1:0]             s2_zhi_reg;
    logic signed [FR_W-1:0]       s2_zp_reg;
    logic signed [FR_W-1:0]       s2_zn_reg;

    // Stage 3 values and registers.
    logic signed [vts_pkg::WT_W-1:0] w_next [vts_pkg::CORNERS];
    logic                            s3_valid_reg;
    logic                            s3_outside_reg;
    logic signed [vts_pkg::WT_W-1:0] s3_weight_reg [vts_pkg::CORNERS];

    assign coord[0]  = coord_x;
    assign coord[1]  = coord_y;
    assign coord[2]  = coord_z;
    assign ext_in[0] = cfg.extent_x;
    assign ext_in[1] = cfg.extent_y;
    assign ext_in[2] = cfg.extent_z;

    // Clamp each axis, take the floor corner and its neighbor, and the fractions.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ext_c[k]  = vts_pkg::clamp_ext(ext_in[k]);
            last_c[k] = IDX_W'(ext_c[k] - EXT_W'(1));
            maxc[k]   = {last_c[k], {FRAC{1'b0}}};
            c_w[k]    = {{(FR_W - CW){coord[k][CW-1]}}, coord[k]};
            below[k]  = coord[k][CW-1];
            above[k]  = c_w[k] > $signed({{(FR_W - CC_W){1'b0}}, maxc[k]});
            if (below[k])
                cc[k] = '0;
            else if (above[k])
                cc[k] = maxc[k];
            else
                cc[k] = c_w[k][CC_W-1:0];
            lo_c[k] = cc[k][CC_W-1:FRAC];
            hi_c[k] = (lo_c[k] == last_c[k]) ? last_c[k] : lo_c[k] + IDX_W'(1);
            p_c[k]  = c_w[k] - $signed({{(FR_W - CC_W){1'b0}}, lo_c[k], {FRAC{1'b0}}});
            n_c[k]  = ONE - p_c[k];
        end
    end

    // Stage 1 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg    <= cmd;
            s1_addr_reg   <= voxel_addr;
            s1_data_reg   <= voxel_data;
            s1_inside_reg <= ~|(below | above);
            for (int k = 0; k < 3; k++)
            begin
                s1_lo_reg[k] <= lo_c[k];
                s1_hi_reg[k] <= hi_c[k];
                s1_p_reg[k]  <= p_c[k];
                s1_n_reg[k]  <= n_c[k];
            end
        end
    end

    // Stage 2: x-y row index and x-y weight for each of the four x-y corners.
    always_comb
    begin
        logic [IDX_W-1:0]     xi;
        logic [IDX_W-1:0]     yi;
        logic [2*EXT_W-1:0]   t;
        logic signed [FR_W-1:0] fx;
        logic signed [FR_W-1:0] fy;
        for (int i = 0; i < 4; i++)
        begin
            xi = i[1] ? s1_hi_reg[0] : s1_lo_reg[0];
            yi = i[0] ? s1_hi_reg[1] : s1_lo_reg[1];
            fx = i[1] ? s1_p_reg[0] : s1_n_reg[0];
            fy = i[0] ? s1_p_reg[1] : s1_n_reg[1];
            t  = xi * vts_pkg::clamp_ext(cfg.extent_y) + yi;
            xy_next[i] = t[XY_W-1:0];
            pq_next[i] = fx * fy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_addr_reg   <= s1_addr_reg;
            s2_data_reg   <= s1_data_reg;
            s2_inside_reg <= s1_inside_reg;
            s2_zlo_reg    <= s1_lo_reg[2];
            s2_zhi_reg    <= s1_hi_reg[2];
            s2_zp_reg     <= s1_p_reg[2];
            s2_zn_reg     <= s1_n_reg[2];
            for (int i = 0; i < 4; i++)
            begin
                s2_xy_reg[i] <= xy_next[i];
                s2_pq_reg[i] <= pq_next[i];
            end
        end
    end

    // Stage 3: full voxel addresses and weights of the eight corners.
    always_comb
    begin
        logic [XY_W+EXT_W-1:0] a;
        for (int k = 0; k < vts_pkg::CORNERS; k++)
        begin
            a = s2_xy_reg[k >> 1] * vts_pkg::clamp_ext(cfg.extent_z)
                + (k[0] ? s2_zhi_reg : s2_zlo_reg);
            ram_raddr[k] = a[vts_pkg::ADDR_W-1:0];
            w_next[k]    = s2_pq_reg[k >> 1] * (k[0] ? s2_zp_reg : s2_zn_reg);
        end
    end

    // Writes reach the store at the same stage as sample reads, keeping order.
    assign ram_we    = en && s2_valid_reg && (s2_cmd_reg == vts_pkg::CMD_WRITE);
    assign ram_waddr = s2_addr_reg;
    assign ram_wdata = s2_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg && (s2_cmd_reg == vts_pkg::CMD_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_outside_reg <= ~s2_inside_reg;
            for (int k = 0; k < vts_pkg::CORNERS; k++)
            begin
                s3_weight_reg[k] <= w_next[k];
            end
        end
    end

    assign s3_valid   = s3_valid_reg;
    assign s3_outside = s3_outside_reg;
    assign s3_weight  = s3_weight_reg;

endmodule

### rtl/vts_blend.sv
// Back end of the sampler: weighted sum tree, nearest-corner selection,
// rounding, saturation and the output register. Depends on vts_pkg.
module vts_blend (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  vts_pkg::cfg_t                      cfg,
    input  logic                               s3_valid,
    input  logic                               s3_outside,
    input  logic signed [vts_pkg::WT_W-1:0]    s3_weight [vts_pkg::CORNERS],
    input  logic signed [vts_pkg::VOX_W-1:0]   s3_voxel [vts_pkg::CORNERS],
    output logic                               out_valid,
    output logic signed [vts_pkg::OUT_W-1:0]   sample_value,
    output logic                               outside_volume,
    output logic                               clipped
);

    localparam int ACC_W = vts_pkg::ACC_W;
    localparam int WT_W  = vts_pkg::WT_W;
    localparam int VOX_W = vts_pkg::VOX_W;
    localparam int SHIFT = 3 * vts_pkg::FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) << (SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (vts_pkg::OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // Stage 4: products and first round of the nearest-corner match.
    logic                              s4_valid_reg;
    logic                              s4_outside_reg;
    logic signed [vts_pkg::PROD_W-1:0] s4_prod_reg [vts_pkg::CORNERS];
    logic signed [WT_W-1:0]            s4_bw_reg [4];
    logic signed [VOX_W-1:0]           s4_bv_reg [4];

    // Stage 5.
    logic                     s5_valid_reg;
    logic                     s5_outside_reg;
    logic signed [ACC_W-1:0]  s5_sum_reg [4];
    logic signed [WT_W-1:0]   s5_bw_reg [2];
    logic signed [VOX_W-1:0]  s5_bv_reg [2];

    // Stage 6.
    logic                     s6_valid_reg;
    logic                     s6_outside_reg;
    logic signed [ACC_W-1:0]  s6_sum_reg [2];
    logic signed [VOX_W-1:0]  s6_near_reg;

    // Output stage.
    logic                          out_valid_reg;
    logic signed [vts_pkg::OUT_W-1:0] value_reg;
    logic signed [vts_pkg::OUT_W-1:0] value_next;
    logic                          outside_reg;
    logic                          clipped_reg;
    logic                          clipped_next;
    logic signed [ACC_W-1:0]       total;
    logic signed [ACC_W-1:0]       scaled;

    // Valid bits of stages 4 to 6 and of the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg  <= s3_valid;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    // Stage 4: corner products; pairwise match keeps the lower corner on a tie.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_outside_reg <= s3_outside;
            for (int k = 0; k < vts_pkg::CORNERS; k++)
            begin
                s4_prod_reg[k] <= s3_weight[k] * s3_voxel[k];
            end
            for (int j = 0; j < 4; j++)
            begin
                if (s3_weight[2*j+1] > s3_weight[2*j])
                begin
                    s4_bw_reg[j] <= s3_weight[2*j+1];
                    s4_bv_reg[j] <= s3_voxel[2*j+1];
                end
                else
                begin
                    s4_bw_reg[j] <= s3_weight[2*j];
                    s4_bv_reg[j] <= s3_voxel[2*j];
                end
            end
        end
    end

    // Stage 5: pair sums and second round of the match.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_outside_reg <= s4_outside_reg;
            for (int j = 0; j < 4; j++)
            begin
                s5_sum_reg[j] <= ACC_W'(s4_prod_reg[2*j]) + ACC_W'(s4_prod_reg[2*j+1]);
            end
            for (int j = 0; j < 2; j++)
            begin
                if (s4_bw_reg[2*j+1] > s4_bw_reg[2*j])
                begin
                    s5_bw_reg[j] <= s4_bw_reg[2*j+1];
                    s5_bv_reg[j] <= s4_bv_reg[2*j+1];
                end
                else
                begin
                    s5_bw_reg[j] <= s4_bw_reg[2*j];
                    s5_bv_reg[j] <= s4_bv_reg[2*j];
                end
            end
        end
    end

    // Stage 6: quad sums and the final match.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_outside_reg <= s5_outside_reg;
            s6_sum_reg[0]  <= s5_sum_reg[0] + s5_sum_reg[1];
            s6_sum_reg[1]  <= s5_sum_reg[2] + s5_sum_reg[3];
            s6_near_reg    <= (s5_bw_reg[1] > s5_bw_reg[0]) ? s5_bv_reg[1] : s5_bv_reg[0];
        end
    end

    // Final sum, round to nearest with ties upward, saturate and pick the result.
    always_comb
    begin
        total        = s6_sum_reg[0] + s6_sum_reg[1] + ROUND;
        scaled       = total >>> SHIFT;
        clipped_next = 1'b0;
        if (cfg.check_bounds && s6_outside_reg)
        begin
            value_next = cfg.fill_value;
        end
        else if (!cfg.interp_mode)
        begin
            value_next = s6_near_reg;
        end
        else if (scaled > SAT_HI)
        begin
            value_next   = SAT_HI[vts_pkg::OUT_W-1:0];
            clipped_next = 1'b1;
        end
        else if (scaled < SAT_LO)
        begin
            value_next   = SAT_LO[vts_pkg::OUT_W-1:0];
            clipped_next = 1'b1;
        end
        else
        begin
            value_next = scaled[vts_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg   <= value_next;
            outside_reg <= s6_outside_reg;
            clipped_reg <= clipped_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_value   = value_reg;
    assign outside_volume = outside_reg;
    assign clipped        = clipped_reg;

endmodule

### rtl/volume_trilinear_sampler.sv
// Volume trilinear sampler, top level: stream ports, configuration registers,
// eight copies of the voxel store. Depends on vts_pkg, vts_ram, vts_front, vts_blend.
// Throughput: one item per cycle while the output is not stalled; the eight corner reads use one store copy each.
// Reset clears all valid bits and loads the register defaults; the voxel store
// is not cleared and each voxel must be written before it is sampled.
module volume_trilinear_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input requests.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: voxel_addr[14:0], voxel_data[30:15], coord_x[45:31],
    //        coord_y[60:46], coord_z[75:61], zero fill[79:76]
    input  logic [79:0]                       s_axis_tdata,
    // tuser: cmd[0]
    input  logic                              s_axis_tuser,
    // Result requests.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: sample_value[15:0]
    output logic [15:0]                       m_axis_tdata,
    // tuser: outside_volume[0], clipped[1]
    output logic [1:0]                        m_axis_tuser,
    // Configuration writes.
    input  logic                              cfg_we,
    input  logic [vts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vts_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CORNERS = vts_pkg::CORNERS;
    localparam int EXT_W   = vts_pkg::EXT_W;

    vts_pkg::cfg_t cfg_reg;
    logic          en;

    logic                            ram_we;
    logic [vts_pkg::ADDR_W-1:0]      ram_waddr;
    logic [vts_pkg::VOX_W-1:0]       ram_wdata;
    logic [vts_pkg::ADDR_W-1:0]      ram_raddr [CORNERS];
    logic [vts_pkg::VOX_W-1:0]       ram_rdata [CORNERS];
    logic signed [vts_pkg::VOX_W-1:0] voxel [CORNERS];

    logic                            s3_valid;
    logic                            s3_outside;
    logic signed [vts_pkg::WT_W-1:0] s3_weight [CORNERS];

    logic                            out_valid;
    logic signed [vts_pkg::OUT_W-1:0] sample_value;
    logic                            outside_volume;
    logic                            clipped;

    // Whole pipeline moves when the output register is free or being taken.
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interp_mode  <= 1'b1;
            cfg_reg.check_bounds <= 1'b1;
            cfg_reg.fill_value   <= '0;
            cfg_reg.extent_x     <= EXT_W'(vts_pkg::MAX_EXTENT);
            cfg_reg.extent_y     <= EXT_W'(vts_pkg::MAX_EXTENT);
            cfg_reg.extent_z     <= EXT_W'(vts_pkg::MAX_EXTENT);
        end
        else if (cfg_we)
        begin
            case (vts_pkg::cfg_reg_t'(cfg_index))
                vts_pkg::REG_INTERP_MODE:  cfg_reg.interp_mode  <= cfg_data[0];
                vts_pkg::REG_CHECK_BOUNDS: cfg_reg.check_bounds <= cfg_data[0];
                vts_pkg::REG_FILL_VALUE:   cfg_reg.fill_value   <= cfg_data[vts_pkg::OUT_W-1:0];
                vts_pkg::REG_EXTENT_X:     cfg_reg.extent_x     <= cfg_data[EXT_W-1:0];
                vts_pkg::REG_EXTENT_Y:     cfg_reg.extent_y     <= cfg_data[EXT_W-1:0];
                vts_pkg::REG_EXTENT_Z:     cfg_reg.extent_z     <= cfg_data[EXT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Address, fraction and weight stages.
    vts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .cmd        (s_axis_tuser),
        .voxel_addr (s_axis_tdata[14:0]),
        .voxel_data (s_axis_tdata[30:15]),
        .coord_x    (s_axis_tdata[45:31]),
        .coord_y    (s_axis_tdata[60:46]),
        .coord_z    (s_axis_tdata[75:61]),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .s3_valid   (s3_valid),
        .s3_outside (s3_outside),
        .s3_weight  (s3_weight)
    );

    // One store copy per corner; every write goes to all copies.
    for (genvar k = 0; k < CORNERS; k++)
    begin : g_store
        vts_ram #(
            .WIDTH (vts_pkg::VOX_W),
            .DEPTH (vts_pkg::DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (en),
            .raddr (ram_raddr[k]),
            .rdata (ram_rdata[k])
        );
        assign voxel[k] = ram_rdata[k];
    end

    // Sum tree, nearest selection and output register.
    vts_blend u_blend (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .cfg            (cfg_reg),
        .s3_valid       (s3_valid),
        .s3_outside     (s3_outside),
        .s3_weight      (s3_weight),
        .s3_voxel       (voxel),
        .out_valid      (out_valid),
        .sample_value   (sample_value),
        .outside_volume (outside_volume),
        .clipped        (clipped)
    );

    assign m_axis_tvalid   = out_valid;
    assign m_axis_tdata    = sample_value;
    assign m_axis_tuser[0] = outside_volume;
    assign m_axis_tuser[1] = clipped;

endmodule
